// ===== hdl/rrc_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, register codes and helpers for the rounded-rectangle coverage block.
// No dependencies; every other file in hdl/ imports this package.
package rrc_pkg;

  // Field widths fixed by the interface
  localparam int PIX_W      = 12;
  localparam int DIM_W      = 13;
  localparam int RAD_W      = 15;
  localparam int RAD_FRAC   = 4;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 15;
  localparam int ALPHA_W    = 8;

  // Largest panel side; wider settings saturate here
  localparam int MAX_DIM = 4096;

  localparam logic [ALPHA_W-1:0] ALPHA_MAX = 8'hFF;

  // Register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] CFG_RECT_WIDTH    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RECT_HEIGHT   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CORNER_RADIUS = 2'd2;

  typedef struct packed {
    logic [PIX_W-1:0] pixel_x;
    logic [PIX_W-1:0] pixel_y;
  } in_item_t;

  typedef struct packed {
    logic               inside_res;
    logic [ALPHA_W-1:0] edge_alpha;
  } out_item_t;

  typedef struct packed {
    logic [DIM_W-1:0] rect_width;
    logic [DIM_W-1:0] rect_height;
    logic [RAD_W-1:0] corner_radius;
  } cfg_regs_t;

  // Zero size reads as one pixel, oversize saturates at MAX_DIM
  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
    logic [DIM_W-1:0] c;
    if (v == '0) begin
      c = DIM_W'(1);
    end else if (int'(v) > MAX_DIM) begin
      c = DIM_W'(MAX_DIM);
    end else begin
      c = v;
    end
    return c;
  endfunction

endpackage

// ===== hdl/rrc_geom.sv =====
`timescale 1ns / 1ps
// Front end: shape setup from the registers, pixel-centre offset from the inner box,
// squared corner distances and the interior term. Depends on rrc_pkg.
module rrc_geom #(
  parameter int FRAC_BITS = 8,
  localparam int LW = rrc_pkg::DIM_W - 1 + FRAC_BITS,
  localparam int SW = 2 * LW + 1,
  localparam int PW = LW + 2
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  rrc_pkg::cfg_regs_t    cfg,
  input  logic                  up_valid,
  output logic                  up_ready,
  input  rrc_pkg::in_item_t     up_data,
  output logic                  dn_valid,
  input  logic                  dn_ready,
  output logic [SW-1:0]         dn_sum,
  output logic signed [PW-1:0]  dn_part
);
  import rrc_pkg::*;

  localparam int NST = 5;
  localparam int QW  = LW + 1;

  // Shape setup, first level: clamped sides, half sizes, radius limit
  logic [DIM_W-1:0] wc, hc, mind;
  logic [LW-1:0]    cx_r, cy_r, maxr_r, rq_r;
  // Shape setup, second level: clamped radius and inner half box
  logic [LW-1:0]    r_sel;
  logic [LW-1:0]    r_r, hx_r, hy_r;

  always_comb begin
    wc   = clamp_dim(cfg.rect_width);
    hc   = clamp_dim(cfg.rect_height);
    mind = (wc < hc) ? wc : hc;
  end

  always_ff @(posedge clk) begin
    cx_r   <= LW'({wc, {FRAC_BITS{1'b0}}} >> 1);
    cy_r   <= LW'({hc, {FRAC_BITS{1'b0}}} >> 1);
    maxr_r <= LW'({mind, {FRAC_BITS{1'b0}}} >> 1);
    rq_r   <= LW'({cfg.corner_radius, {FRAC_BITS{1'b0}}} >> RAD_FRAC);
  end

  assign r_sel = (rq_r > maxr_r) ? maxr_r : rq_r;

  always_ff @(posedge clk) begin
    r_r  <= r_sel;
    hx_r <= cx_r - r_sel;
    hy_r <= cy_r - r_sel;
  end

  // Stage handshake: a stage loads when empty or when its successor moves
  logic [NST-1:0] v_r;
  logic [NST:0]   en;

  assign en[NST] = dn_ready;
  for (genvar i = 0; i < NST; i++) begin : g_en
    assign en[i] = !v_r[i] || en[i+1];
  end
  assign up_ready = en[0];
  assign dn_valid = v_r[NST-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      for (int i = 0; i < NST; i++) begin
        if (en[i]) begin
          v_r[i] <= (i == 0) ? up_valid : v_r[i-1];
        end
      end
    end
  end

  // Stage 1: input register
  logic [PIX_W-1:0] x_r, y_r;

  always_ff @(posedge clk) begin
    if (en[0]) begin
      x_r <= up_data.pixel_x;
      y_r <= up_data.pixel_y;
    end
  end

  // Stage 2: |pixel centre - box centre|
  logic [LW-1:0]        px, py;
  logic signed [LW:0]   dfx, dfy;
  logic [LW-1:0]        dx_r, dy_r;

  assign px  = LW'({x_r, 1'b1, {(FRAC_BITS-1){1'b0}}});
  assign py  = LW'({y_r, 1'b1, {(FRAC_BITS-1){1'b0}}});
  assign dfx = signed'({1'b0, px}) - signed'({1'b0, cx_r});
  assign dfy = signed'({1'b0, py}) - signed'({1'b0, cy_r});

  always_ff @(posedge clk) begin
    if (en[1]) begin
      dx_r <= dfx[LW] ? LW'(-dfx) : LW'(dfx);
      dy_r <= dfy[LW] ? LW'(-dfy) : LW'(dfy);
    end
  end

  // Stage 3: offset from the inner box
  logic signed [QW-1:0] qx_r, qy_r;

  always_ff @(posedge clk) begin
    if (en[2]) begin
      qx_r <= signed'({1'b0, dx_r}) - signed'({1'b0, hx_r});
      qy_r <= signed'({1'b0, dy_r}) - signed'({1'b0, hy_r});
    end
  end

  // Stage 4: squares of the positive parts, interior term minus radius
  logic [LW-1:0]        ox, oy;
  logic signed [QW-1:0] mq, inner;
  logic [2*LW-1:0]      sqx_r, sqy_r;
  logic signed [PW-1:0] part4_r;

  assign ox    = qx_r[QW-1] ? '0 : qx_r[LW-1:0];
  assign oy    = qy_r[QW-1] ? '0 : qy_r[LW-1:0];
  assign mq    = (qx_r > qy_r) ? qx_r : qy_r;
  assign inner = mq[QW-1] ? mq : '0;

  always_ff @(posedge clk) begin
    if (en[3]) begin
      sqx_r   <= ox * ox;
      sqy_r   <= oy * oy;
      part4_r <= signed'({inner[QW-1], inner}) - signed'({2'b00, r_r});
    end
  end

  // Stage 5: sum of squares
  logic [SW-1:0]        sum_r;
  logic signed [PW-1:0] part5_r;

  always_ff @(posedge clk) begin
    if (en[4]) begin
      sum_r   <= {1'b0, sqx_r} + {1'b0, sqy_r};
      part5_r <= part4_r;
    end
  end

  assign dn_sum  = sum_r;
  assign dn_part = part5_r;

endmodule

// ===== hdl/rrc_sqrt.sv =====
`timescale 1ns / 1ps
// Pipelined integer square root, one result bit per stage, rounded half up at the end.
// Carries the interior term alongside. Depends on rrc_pkg.
module rrc_sqrt #(
  parameter int FRAC_BITS = 8,
  localparam int LW = rrc_pkg::DIM_W - 1 + FRAC_BITS,
  localparam int SW = 2 * LW + 1,
  localparam int PW = LW + 2,
  localparam int RW = LW + 2
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  up_valid,
  output logic                  up_ready,
  input  logic [SW-1:0]         up_sum,
  input  logic signed [PW-1:0]  up_part,
  output logic                  dn_valid,
  input  logic                  dn_ready,
  output logic [RW-1:0]         dn_root,
  output logic signed [PW-1:0]  dn_part
);
  import rrc_pkg::*;

  // One stage per root bit, plus the rounding stage
  localparam int K   = LW + 1;
  localparam int NST = K + 1;

  logic [NST-1:0] v_r;
  logic [NST:0]   en;

  assign en[NST] = dn_ready;
  for (genvar i = 0; i < NST; i++) begin : g_en
    assign en[i] = !v_r[i] || en[i+1];
  end
  assign up_ready = en[0];
  assign dn_valid = v_r[NST-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      for (int i = 0; i < NST; i++) begin
        if (en[i]) begin
          v_r[i] <= (i == 0) ? up_valid : v_r[i-1];
        end
      end
    end
  end

  logic [SW-1:0]        res_r [K];
  logic [SW-1:0]        rem_r [K];
  logic signed [PW-1:0] prt_r [NST];

  // Restoring digit steps, highest bit pair first
  for (genvar k = 0; k < K; k++) begin : g_step
    localparam logic [SW-1:0] BIT = SW'(1) << (2 * (K - 1 - k));
    logic [SW-1:0]        res_in, rem_in;
    logic signed [PW-1:0] prt_in;
    logic [SW:0]          trial;

    if (k == 0) begin : g_first
      assign res_in = '0;
      assign rem_in = up_sum;
      assign prt_in = up_part;
    end else begin : g_next
      assign res_in = res_r[k-1];
      assign rem_in = rem_r[k-1];
      assign prt_in = prt_r[k-1];
    end

    assign trial = {1'b0, res_in} + {1'b0, BIT};

    always_ff @(posedge clk) begin
      if (en[k]) begin
        if ({1'b0, rem_in} >= trial) begin
          rem_r[k] <= rem_in - SW'(trial);
          res_r[k] <= (res_in >> 1) + BIT;
        end else begin
          rem_r[k] <= rem_in;
          res_r[k] <= res_in >> 1;
        end
        prt_r[k] <= prt_in;
      end
    end
  end

  // Round: bump when the remainder exceeds the root
  logic [RW-1:0] root_r;

  always_ff @(posedge clk) begin
    if (en[K]) begin
      root_r   <= RW'(res_r[K-1]) + RW'(rem_r[K-1] > res_r[K-1]);
      prt_r[K] <= prt_r[K-1];
    end
  end

  assign dn_root = root_r;
  assign dn_part = prt_r[K];

endmodule

// ===== hdl/rrc_alpha.sv =====
`timescale 1ns / 1ps
// Back end: signed distance, inside test and rounded edge alpha, with the output register.
// Depends on rrc_pkg.
module rrc_alpha #(
  parameter int FRAC_BITS = 8,
  localparam int LW = rrc_pkg::DIM_W - 1 + FRAC_BITS,
  localparam int PW = LW + 2,
  localparam int RW = LW + 2
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  up_valid,
  output logic                  up_ready,
  input  logic [RW-1:0]         up_root,
  input  logic signed [PW-1:0]  up_part,
  output logic                  dn_valid,
  input  logic                  dn_ready,
  output rrc_pkg::out_item_t    dn_data
);
  import rrc_pkg::*;

  localparam int NST = 3;
  localparam int DW  = LW + 3;
  localparam int MW  = FRAC_BITS + ALPHA_W;
  localparam logic [MW-1:0] HALF = MW'(1) << (FRAC_BITS - 1);

  logic [NST-1:0] v_r;
  logic [NST:0]   en;

  assign en[NST] = dn_ready;
  for (genvar i = 0; i < NST; i++) begin : g_en
    assign en[i] = !v_r[i] || en[i+1];
  end
  assign up_ready = en[0];
  assign dn_valid = v_r[NST-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      for (int i = 0; i < NST; i++) begin
        if (en[i]) begin
          v_r[i] <= (i == 0) ? up_valid : v_r[i-1];
        end
      end
    end
  end

  // Stage 1: distance = outer length + interior term - radius
  logic signed [DW-1:0] dist_r;

  always_ff @(posedge clk) begin
    if (en[0]) begin
      dist_r <= signed'({1'b0, up_root}) + signed'({up_part[PW-1], up_part});
    end
  end

  // Stage 2: inside flag, depth below the edge, saturation at one pixel
  logic signed [DW-1:0]   nd;
  logic                   in_r, sat_r;
  logic [FRAC_BITS-1:0]   nd_r;

  assign nd = -dist_r;

  always_ff @(posedge clk) begin
    if (en[1]) begin
      in_r  <= dist_r[DW-1] || (dist_r == '0);
      sat_r <= |nd[DW-1:FRAC_BITS];
      nd_r  <= nd[FRAC_BITS-1:0];
    end
  end

  // Stage 3: alpha = (depth * 255 + half) >> FRAC_BITS, output register
  logic [MW-1:0]      prod;
  out_item_t          out_r;

  assign prod = ({nd_r, {ALPHA_W{1'b0}}} - MW'(nd_r)) + HALF;

  always_ff @(posedge clk) begin
    if (en[2]) begin
      out_r.inside_res <= in_r;
      if (!in_r) begin
        out_r.edge_alpha <= '0;
      end else if (sat_r) begin
        out_r.edge_alpha <= ALPHA_MAX;
      end else begin
        out_r.edge_alpha <= prod[MW-1:FRAC_BITS];
      end
    end
  end

  assign dn_data = out_r;

endmodule

// ===== hdl/rounded_rect_coverage_mask.sv =====
`timescale 1ns / 1ps
// Top level of the rounded-rectangle coverage block: registers, front end, root, back end.
// Depends on rrc_pkg, rrc_geom, rrc_sqrt and rrc_alpha.
//
//   port group  direction  handshake        payload
//   in_*        input      valid / ready    in_data  : pixel_x, pixel_y
//   out_*       output     valid / ready    out_data : inside_res, edge_alpha
//   cfg_*       input      write enable     cfg_index, cfg_wdata (no read-back)
//
// One pixel per clock sustained while out_ready is high; 5 front-end stages,
// FRAC_BITS + 14 square-root stages (one per root bit, plus rounding), 3 back-end.
// Synchronous active-low reset empties the pipe and loads width 1, height 1, radius 0.
// Each stage fills when empty, so the input keeps taking pixels while a result waits
// until every stage is full; a stall drops and repeats nothing.
// Shape setup is registered in two levels; a write also reaches pixels already in flight.
module rounded_rect_coverage_mask #(
  parameter int FRAC_BITS = 8
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  rrc_pkg::in_item_t                in_data,
  output logic                             out_valid,
  input  logic                             out_ready,
  output rrc_pkg::out_item_t               out_data,
  input  logic                             cfg_we,
  input  logic [rrc_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [rrc_pkg::CFG_DATA_W-1:0]   cfg_wdata
);
  import rrc_pkg::*;

  localparam int LW = DIM_W - 1 + FRAC_BITS;
  localparam int SW = 2 * LW + 1;
  localparam int PW = LW + 2;
  localparam int RW = LW + 2;

  // Configuration registers
  cfg_regs_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.rect_width    <= DIM_W'(1);
      cfg_r.rect_height   <= DIM_W'(1);
      cfg_r.corner_radius <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_RECT_WIDTH:    cfg_r.rect_width    <= cfg_wdata[DIM_W-1:0];
        CFG_RECT_HEIGHT:   cfg_r.rect_height   <= cfg_wdata[DIM_W-1:0];
        CFG_CORNER_RADIUS: cfg_r.corner_radius <= cfg_wdata[RAD_W-1:0];
        default: ;
      endcase
    end
  end

  // Front end to root
  logic                 g_valid, g_ready;
  logic [SW-1:0]        g_sum;
  logic signed [PW-1:0] g_part;

  rrc_geom #(.FRAC_BITS(FRAC_BITS)) u_geom (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .up_valid (in_valid),
    .up_ready (in_ready),
    .up_data  (in_data),
    .dn_valid (g_valid),
    .dn_ready (g_ready),
    .dn_sum   (g_sum),
    .dn_part  (g_part)
  );

  // Root to back end
  logic                 s_valid, s_ready;
  logic [RW-1:0]        s_root;
  logic signed [PW-1:0] s_part;

  rrc_sqrt #(.FRAC_BITS(FRAC_BITS)) u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (g_valid),
    .up_ready (g_ready),
    .up_sum   (g_sum),
    .up_part  (g_part),
    .dn_valid (s_valid),
    .dn_ready (s_ready),
    .dn_root  (s_root),
    .dn_part  (s_part)
  );

  rrc_alpha #(.FRAC_BITS(FRAC_BITS)) u_alpha (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (s_valid),
    .up_ready (s_ready),
    .up_root  (s_root),
    .up_part  (s_part),
    .dn_valid (out_valid),
    .dn_ready (out_ready),
    .dn_data  (out_data)
  );

  // A pixel outside the shape never carries coverage
  a_outside_no_alpha: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.inside_res |-> out_data.edge_alpha == '0)
    else $error("coverage on an outside pixel");

  // The input only backs up when the output is holding a stalled result
  a_stall_source: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid && !out_ready)
    else $error("input stalled with the output free");

  // A stalled full pipe still offers its result in the cycle after the stall
  a_full_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready && !in_ready |=> out_valid)
    else $error("result lost from a stalled full pipe");

endmodule

// ===== tb/tb_rounded_rect_coverage_mask.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for rounded_rect_coverage_mask: directed shapes, random shapes
// and output backpressure, with a built-in coverage predictor. Depends on rrc_pkg and the RTL.
module tb_rounded_rect_coverage_mask;
  import rrc_pkg::*;

  localparam int FRAC      = 8;
  localparam longint ONE   = longint'(1) << FRAC;
  localparam longint HALF  = ONE >> 1;
  localparam int WATCHDOG  = 5000;
  localparam int DRAIN_CYC = 40;
  localparam int HOLD_CYC  = 300;

  typedef struct packed {
    in_item_t  pix;
    out_item_t cov;
  } coverage_expect_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  in_item_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_item_t out_data;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_RECT_WIDTH;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  // Shadow copy of the shape registers, reset values
  logic [DIM_W-1:0] shape_w = DIM_W'(1);
  logic [DIM_W-1:0] shape_h = DIM_W'(1);
  logic [RAD_W-1:0] shape_r = '0;

  coverage_expect_t coverage_q[$];
  int mismatches = 0;
  int quiet_cycles = 0;
  bit gaps_on = 1'b1;
  bit stalls_on = 1'b1;
  int hold_request = 0;

  rounded_rect_coverage_mask #(.FRAC_BITS(FRAC)) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // ---------------------------------------------------------------- predictor
  function automatic longint sat_side(input logic [DIM_W-1:0] v);
    longint s;
    s = longint'(v);
    if (s == 0) s = 1;
    if (s > MAX_DIM) s = MAX_DIM;
    return s;
  endfunction

  // Floor root bit by bit, then round to nearest with ties up
  function automatic longint unsigned round_sqrt(input longint unsigned s);
    longint unsigned root, cand;
    root = 0;
    for (int b = 23; b >= 0; b--) begin
      cand = root | (longint'(1) << b);
      if (cand * cand <= s) root = cand;
    end
    if (s - root * root > root) root = root + 1;
    return root;
  endfunction

  function automatic out_item_t coverage_of(input in_item_t p);
    longint w, h, r, maxr, cx, cy, qx, qy, ox, oy, outer, inner, sdist, nd, alpha, d;
    out_item_t res;
    w = sat_side(shape_w);
    h = sat_side(shape_h);
    maxr = ((w < h ? w : h) << FRAC) >> 1;
    r = (longint'(shape_r) << FRAC) >> RAD_FRAC;
    if (r > maxr) r = maxr;
    cx = (w << FRAC) >> 1;
    cy = (h << FRAC) >> 1;
    // Offset of the pixel centre from the radius-shrunk inner box
    d = (longint'(p.pixel_x) << FRAC) + HALF - cx;
    if (d < 0) d = -d;
    qx = d - (cx - r);
    d = (longint'(p.pixel_y) << FRAC) + HALF - cy;
    if (d < 0) d = -d;
    qy = d - (cy - r);
    ox = qx > 0 ? qx : 0;
    oy = qy > 0 ? qy : 0;
    outer = longint'(round_sqrt(longint'(ox * ox + oy * oy)));
    inner = qx > qy ? qx : qy;
    if (inner > 0) inner = 0;
    sdist = outer + inner - r;
    res = '0;
    if (sdist <= 0) begin
      nd = -sdist;
      res.inside_res = 1'b1;
      alpha = (nd >= ONE) ? 255 : ((nd * 255 + HALF) >> FRAC);
      if (alpha > 255) alpha = 255;
      res.edge_alpha = alpha[ALPHA_W-1:0];
    end
    return res;
  endfunction

  // ---------------------------------------------------------------- drivers
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int value);
    logic [CFG_DATA_W-1:0] v;
    v = CFG_DATA_W'(value);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= v;
    case (idx)
      CFG_RECT_WIDTH:    shape_w = v[DIM_W-1:0];
      CFG_RECT_HEIGHT:   shape_h = v[DIM_W-1:0];
      CFG_CORNER_RADIUS: shape_r = v[RAD_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_shape(input int w, input int h, input int r);
    write_reg(CFG_RECT_WIDTH, w);
    write_reg(CFG_RECT_HEIGHT, h);
    write_reg(CFG_CORNER_RADIUS, r);
  endtask

  // One pixel transfer; valid stays up after the transfer until the next call decides
  task automatic send_pixel(input int x, input int y);
    int gap;
    in_item_t p;
    coverage_expect_t e;
    p.pixel_x = PIX_W'(x);
    p.pixel_y = PIX_W'(y);
    gap = gaps_on ? $urandom_range(19, 0) : 0;
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= p;
    do @(posedge clk); while (!in_ready);
    e.pix = p;
    e.cov = coverage_of(p);
    coverage_q.insert(coverage_q.size(), e);
  endtask

  // Drop valid and wait until every pending result has come back
  task automatic finish_batch();
    @(negedge clk);
    in_valid <= 1'b0;
    while (coverage_q.size() != 0) @(posedge clk);
  endtask

  // ---------------------------------------------------------------- receiver
  initial begin
    int stall_left, hold_left;
    stall_left = 0;
    hold_left = 0;
    forever begin
      @(negedge clk);
      if (hold_request > 0) begin
        hold_left = hold_request;
        hold_request = 0;
      end
      if (hold_left > 0) begin
        out_ready <= 1'b0;
        hold_left--;
      end else if (stall_left > 0) begin
        out_ready <= 1'b0;
        stall_left--;
      end else begin
        out_ready <= 1'b1;
      end
      @(posedge clk);
      if (out_valid && out_ready) stall_left = stalls_on ? $urandom_range(19, 0) : 0;
    end
  end

  // ---------------------------------------------------------------- checker
  always @(posedge clk) begin
    coverage_expect_t e;
    if (rst_n && out_valid && out_ready) begin
      if (coverage_q.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected result inside_res %0b edge_alpha %0d", $time,
                 out_data.inside_res, out_data.edge_alpha);
      end else begin
        e = coverage_q.pop_front();
        if (out_data.inside_res !== e.cov.inside_res) begin
          mismatches++;
          $display("%0t: pixel (%0d,%0d) inside_res expected %0b actual %0b", $time,
                   e.pix.pixel_x, e.pix.pixel_y, e.cov.inside_res, out_data.inside_res);
        end
        if (out_data.edge_alpha !== e.cov.edge_alpha) begin
          mismatches++;
          $display("%0t: pixel (%0d,%0d) edge_alpha expected %0d actual %0d", $time,
                   e.pix.pixel_x, e.pix.pixel_y, e.cov.edge_alpha, out_data.edge_alpha);
        end
      end
    end
  end

  // Watchdog on cycles without any transfer
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles + 1 >= WATCHDOG) begin
        $display("** rounded_rect_coverage_mask: FAILED **");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------- tests
  // Reset shape is a 1x1 square with no rounding
  task automatic test_reset_shape();
    send_pixel(0, 0);
    send_pixel(1, 0);
    send_pixel(0, 1);
    send_pixel(4095, 4095);
    finish_batch();
  endtask

  // Zero width and height read as one pixel
  task automatic test_zero_size();
    set_shape(0, 0, 0);
    send_pixel(0, 0);
    send_pixel(1, 1);
    finish_batch();
  endtask

  // Oversize sides saturate; a huge radius clamps to half the smaller side
  task automatic test_oversize_huge_radius();
    set_shape(8191, 4096, 32767);
    send_pixel(0, 0);
    send_pixel(4095, 0);
    send_pixel(0, 4095);
    send_pixel(4095, 4095);
    send_pixel(2048, 2048);
    send_pixel(2047, 0);
    send_pixel(600, 600);
    finish_batch();
  endtask

  // Pixels on and past the shape border, out to the panel edge
  task automatic test_beyond_panel();
    set_shape(100, 50, 160);
    send_pixel(99, 49);
    send_pixel(100, 25);
    send_pixel(4095, 25);
    send_pixel(50, 4095);
    send_pixel(0, 0);
    send_pixel(50, 0);
    send_pixel(2, 2);
    send_pixel(0, 25);
    finish_batch();
  endtask

  function automatic int pick_side();
    case ($urandom_range(7, 0))
      0: return 0;
      1: return $urandom_range(8191, 4096);
      2: return $urandom_range(4, 1);
      3: return $urandom_range(8191, 0);
      default: return $urandom_range(300, 1);
    endcase
  endfunction

  function automatic int pick_radius();
    int lim;
    lim = int'(sat_side(shape_w) < sat_side(shape_h) ? sat_side(shape_w) : sat_side(shape_h));
    lim = lim * 8 + 16;
    if (lim > 32767) lim = 32767;
    case ($urandom_range(5, 0))
      0: return 0;
      1: return 32767;
      2: return $urandom_range(32767, 0);
      default: return $urandom_range(lim, 0);
    endcase
  endfunction

  // Half near the borders and corners, the rest anywhere inside the side or in the 12-bit range
  function automatic int pick_coord(input int side);
    int c;
    case ($urandom_range(5, 0))
      0: c = $urandom_range(4095, 0);
      1: c = int'($urandom_range(5, 0));
      2: c = side - 1 - int'($urandom_range(5, 0));
      3: c = side + int'($urandom_range(3, 0));
      default: c = int'($urandom_range(side - 1, 0));
    endcase
    if (c < 0) c = 0;
    if (c > 4095) c = 4095;
    return c;
  endfunction

  task automatic test_random_shapes(input int phases, input int per_phase);
    int w, h;
    for (int ph = 0; ph < phases; ph++) begin
      w = pick_side();
      h = pick_side();
      write_reg(CFG_RECT_WIDTH, w);
      write_reg(CFG_RECT_HEIGHT, h);
      write_reg(CFG_CORNER_RADIUS, pick_radius());
      gaps_on = (ph % 4 == 0) || (ph % 4 == 1);
      stalls_on = (ph % 4 == 0) || (ph % 4 == 2);
      for (int i = 0; i < per_phase; i++)
        send_pixel(pick_coord(int'(sat_side(shape_w))), pick_coord(int'(sat_side(shape_h))));
      finish_batch();
    end
  endtask

  // Receiver holds off for a long stretch while pixels keep coming back to back
  task automatic test_output_backpressure();
    set_shape(64, 40, 200);
    gaps_on = 1'b0;
    stalls_on = 1'b0;
    hold_request = HOLD_CYC;
    for (int i = 0; i < 150; i++) send_pixel(pick_coord(64), pick_coord(40));
    finish_batch();
    gaps_on = 1'b1;
    stalls_on = 1'b1;
  endtask

  initial begin
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_reset_shape();
    test_zero_size();
    test_oversize_huge_radius();
    test_beyond_panel();
    test_random_shapes(8, 250);
    test_output_backpressure();

    repeat (DRAIN_CYC) @(posedge clk);
    if (mismatches == 0 && coverage_q.size() == 0) begin
      $display("** rounded_rect_coverage_mask: PASSED **");
    end else begin
      $display("** rounded_rect_coverage_mask: FAILED **");
    end
    $finish;
  end

endmodule

// ===== rounded_rect_coverage_mask.f =====
hdl/rrc_pkg.sv
hdl/rrc_geom.sv
hdl/rrc_sqrt.sv
hdl/rrc_alpha.sv
hdl/rounded_rect_coverage_mask.sv
tb/tb_rounded_rect_coverage_mask.sv
